>>> hdl/tcf_pkg.sv
// Package for the tilt complementary filter: payload structs, register
// indexes, fixed-point constants, the CORDIC arctangent table, saturation.
// No dependencies.
package tcf_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] gyro_pitch_raw;
    logic signed [15:0] gyro_yaw_raw;
    logic               publish_pitch;
  } tcf_in_t;

  typedef struct packed {
    logic signed [8:0]  pitch_degrees;
    logic signed [15:0] yaw_degrees;
  } tcf_out_t;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT = 2'd0,
    CFG_PERIOD = 2'd1
  } tcf_cfg_e;

  localparam logic [15:0] WeightRst = 16'd229;
  localparam logic [15:0] PeriodRst = 16'd328;

  // CORDIC datapath
  localparam int unsigned TableLen = 24;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned VecW     = 36;
  localparam int unsigned AngW     = 32;
  localparam logic signed [AngW-1:0] HalfTurn = 32'sd11796480; // 180 deg, Q16.16

  // Divide by 16.4 is *5 then /82
  localparam int unsigned DivW     = 34;
  localparam logic [7:0]  DivConst = 8'd82;
  // ceil(2^32 / 82), exact for dividends below 2^30
  localparam logic [25:0] RecipDiv = 26'd52377650;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic [21:0] atan_deg(input logic [IdxW-1:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/tcf_cordic.sv
// Vectoring CORDIC: atan2(y, x) in Q16.16 degrees, one iteration per cycle.
// Depends on tcf_pkg (table, widths).
module tcf_cordic #(
  parameter int unsigned IterN = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [15:0]              y_i,
  input  logic signed [15:0]              x_i,
  output logic                            busy_o,
  output logic signed [tcf_pkg::AngW-1:0] angle_o
);
  import tcf_pkg::*;

  logic signed [VecW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [VecW-1:0] x_ext, y_ext, dx, dy;
  logic signed [AngW-1:0] z_q, z_d, step_ang;
  logic [IdxW-1:0]        it_q, it_d;
  logic                   busy_q, busy_d;

  assign x_ext    = VecW'(x_i);
  assign y_ext    = VecW'(y_i);
  assign dx       = cy_q >>> it_q;
  assign dy       = cx_q >>> it_q;
  assign step_ang = $signed({{(AngW-22){1'b0}}, atan_deg(it_q)});

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    z_d    = z_q;
    it_d   = it_q;
    busy_d = busy_q;
    if (start_i) begin
      it_d = '0;
      if (x_i == 16'sd0 && y_i == 16'sd0) begin
        z_d    = '0;
        busy_d = 1'b0;
      end else if (x_i < 16'sd0) begin
        // mirror into the right half plane, start at +-180
        z_d    = (y_i >= 16'sd0) ? HalfTurn : -HalfTurn;
        cx_d   = (-x_ext) <<< 16;
        cy_d   = (-y_ext) <<< 16;
        busy_d = 1'b1;
      end else begin
        z_d    = '0;
        cx_d   = x_ext <<< 16;
        cy_d   = y_ext <<< 16;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cy_q > 0) begin
        cx_d = cx_q + dx;
        cy_d = cy_q - dy;
        z_d  = z_q + step_ang;
      end else begin
        cx_d = cx_q - dx;
        cy_d = cy_q + dy;
        z_d  = z_q - step_ang;
      end
      if (it_q == IdxW'(IterN - 1)) begin
        busy_d = 1'b0;
      end else begin
        it_d = it_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    z_q  <= z_d;
  end

  assign busy_o  = busy_q;
  assign angle_o = z_q;

endmodule

>>> hdl/tilt_complementary_filter_unit.sv
// Top level of the tilt complementary filter: sequencer, shared multiplier,
// divide by 82 by reciprocal, state and output register. Uses tcf_pkg, tcf_cordic.
//
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  in_data_i   (tcf_in_t)
// out      out  out_valid_o/out_ready_i out_data_o (tcf_out_t)
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// At 16 iterations the CORDIC sets the time from an input transfer to the next possible
// one; the two-half reciprocal divide by 82 and the yaw update run beside it. One 36x27
// multiplier serves all products but the quotient digit times 82 in the divider.
// Reset clears the filter state and loads the register defaults.
// A result waits in the output register; the next item is taken meanwhile
// and only its final load stalls on out_ready_i. Config is always ready.
module tilt_complementary_filter_unit #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcf_pkg::tcf_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcf_pkg::tcf_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import tcf_pkg::*;

  localparam int unsigned IterN =
    (CORDIC_ITERATIONS > TableLen) ? TableLen : CORDIC_ITERATIONS;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL0   = 11'b00000000010,
    S_DIVH   = 11'b00000000100,
    S_DIVL   = 11'b00000001000,
    S_MUL1   = 11'b00000010000,
    S_MUL2   = 11'b00000100000,
    S_WAIT   = 11'b00001000000,
    S_BLEND0 = 11'b00010000000,
    S_BLEND1 = 11'b00100000000,
    S_UPD    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]        w_q, w_d, dt_q, dt_d;
  logic signed [31:0] pe_q, pe_d, ya_q, ya_d;
  logic signed [8:0]  held_q, held_d;
  logic signed [15:0] gy_q, gz_q;
  logic               pub_q;
  logic [DivW-1:0]    dq_q, dq_d;
  logic [10:0]        qh_q, qh_d;
  logic               dneg_q, dneg_d;
  logic signed [11:0] rate_q, rate_d;
  logic signed [51:0] acc_q, acc_d;
  tcf_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic                   start;
  logic                   cordic_busy;
  logic signed [AngW-1:0] acc_pitch;

  logic signed [35:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [62:0] mul_p;

  logic signed [34:0] m5;
  logic [34:0]        m5_mag;
  logic signed [18:0] gz5;
  logic [18:0]        gz5_mag;
  logic [10:0]        rate_mag;
  logic signed [32:0] yaw_sum;
  logic signed [27:0] step;
  logic signed [33:0] diff;
  logic [16:0]        w_compl;
  logic [10:0]        qh_new;
  logic [17:0]        qh_x82;
  logic [6:0]         rh;
  logic signed [51:0] blend_sh;
  logic signed [15:0] pitch_deg, yaw_deg;
  logic signed [8:0]  held_new;

  function automatic logic signed [15:0] trunc_deg(input logic signed [31:0] v);
    logic signed [15:0] f;
    f = v[31:16];
    if (v[31] && v[15:0] != 16'd0) begin
      f = f + 16'sd1;
    end
    return f;
  endfunction

  assign start = in_valid_i & in_ready_o;

  tcf_cordic #(
    .IterN (IterN)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .y_i     (in_data_i.accel_x_raw),
    .x_i     (in_data_i.accel_z_raw),
    .busy_o  (cordic_busy),
    .angle_o (acc_pitch)
  );

  // shared multiplier operand select
  assign w_compl = 17'h10000 - {1'b0, w_q};
  assign step    = dneg_q ? -$signed({1'b0, dq_q[26:0]}) : $signed({1'b0, dq_q[26:0]});
  assign diff    = 34'(pe_q) - 34'(step);
  assign gz5     = (19'(gz_q) <<< 2) + 19'(gz_q);
  assign gz5_mag = gz5[18] ? 19'(-gz5) : 19'(gz5);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL0: begin
        mul_a = 36'(gy_q);
        mul_b = $signed({11'b0, dt_q});
      end
      S_DIVH: begin
        mul_a = $signed({19'b0, dq_q[DivW-1:17]});
        mul_b = $signed({1'b0, RecipDiv});
      end
      S_DIVL: begin
        mul_a = $signed({12'b0, dq_q[23:0]});
        mul_b = $signed({1'b0, RecipDiv});
      end
      S_MUL1: begin
        mul_a = $signed({17'b0, gz5_mag});
        mul_b = $signed({1'b0, RecipDiv});
      end
      S_MUL2: begin
        mul_a = 36'(rate_q);
        mul_b = $signed({11'b0, dt_q});
      end
      S_BLEND0: begin
        mul_a = 36'(diff);
        mul_b = $signed({10'b0, w_compl});
      end
      S_BLEND1: begin
        mul_a = 36'(acc_pitch);
        mul_b = $signed({11'b0, w_q});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign m5       = (35'($signed(mul_p[32:0])) <<< 2) + 35'($signed(mul_p[32:0]));
  assign m5_mag   = m5[34] ? 35'(-m5) : 35'(m5);
  assign rate_mag = mul_p[42:32];
  assign yaw_sum  = 33'(ya_q) + 33'($signed(mul_p[27:0]));
  assign blend_sh = acc_q >>> 16;

  // long division by 82 in two 17-bit digits: high quotient and its remainder
  assign qh_new = mul_p[42:32];
  assign qh_x82 = 18'(qh_new) * 18'(DivConst);
  assign rh     = 7'(dq_q[DivW-1:17] - qh_x82[16:0]);

  assign pitch_deg = trunc_deg(pe_q);
  assign yaw_deg   = trunc_deg(ya_q);

  always_comb begin
    if (pitch_deg > 16'sd255) begin
      held_new = 9'sd255;
    end else if (pitch_deg < -16'sd256) begin
      held_new = -9'sd256;
    end else begin
      held_new = pitch_deg[8:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    pe_d        = pe_q;
    ya_d        = ya_q;
    held_d      = held_q;
    dq_d        = dq_q;
    qh_d        = qh_q;
    dneg_d      = dneg_q;
    rate_d      = rate_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        dneg_d  = m5[34];
        dq_d    = m5_mag[DivW-1:0];
        state_d = S_DIVH;
      end
      S_DIVH: begin
        qh_d    = qh_new;
        dq_d    = DivW'({rh, dq_q[16:0]});
        state_d = S_DIVL;
      end
      S_DIVL: begin
        dq_d    = DivW'({qh_q, mul_p[48:32]});
        state_d = S_MUL1;
      end
      S_MUL1: begin
        rate_d  = gz5[18] ? -$signed({1'b0, rate_mag}) : $signed({1'b0, rate_mag});
        state_d = S_MUL2;
      end
      S_MUL2: begin
        ya_d    = sat32(52'(yaw_sum));
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!cordic_busy) begin
          state_d = S_BLEND0;
        end
      end
      S_BLEND0: begin
        acc_d   = $signed(mul_p[51:0]);
        state_d = S_BLEND1;
      end
      S_BLEND1: begin
        acc_d   = acc_q + $signed(mul_p[51:0]);
        state_d = S_UPD;
      end
      S_UPD: begin
        pe_d    = sat32(blend_sh);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          if (pub_q) begin
            held_d              = held_new;
            out_d.pitch_degrees = held_new;
          end else begin
            out_d.pitch_degrees = held_q;
          end
          out_d.yaw_degrees = yaw_deg;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    w_d  = w_q;
    dt_d = dt_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WEIGHT: w_d  = cfg_data_i;
        CFG_PERIOD: dt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= WeightRst;
      dt_q        <= PeriodRst;
      pe_q        <= '0;
      ya_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      dt_q        <= dt_d;
      pe_q        <= pe_d;
      ya_q        <= ya_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      gy_q  <= in_data_i.gyro_pitch_raw;
      gz_q  <= in_data_i.gyro_yaw_raw;
      pub_q <= in_data_i.publish_pitch;
    end
    dq_q   <= dq_d;
    qh_q   <= qh_d;
    dneg_q <= dneg_d;
    rate_q <= rate_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> bench/testbench.sv
// Self-checking bench for tilt_complementary_filter_unit: drives IMU samples and register
// writes, predicts pitch and yaw per sample, compares every result transfer in order.
// Depends on tcf_pkg and the filter RTL.
`timescale 1ns / 1ps

module testbench;
  import tcf_pkg::*;

  localparam int unsigned CordicIters = 16;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 60;   // well over the time one item takes
  localparam int HoldCycles  = 800;
  localparam int IdlePct     = 30;
  localparam longint HalfTurnQ16 = 64'sd11796480;
  localparam longint Q32Max = 64'sd2147483647;
  localparam longint Q32Min = -64'sd2147483648;
  // indexes past the last register, must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  tcf_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tcf_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  // predictor state and register shadows
  longint pitch_est_q16;
  longint yaw_acc_q16;
  logic signed [8:0] pitch_hold;
  longint trust_weight;
  longint step_period;

  tcf_out_t tilt_results_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  logic steady = 1'b0;        // no idling on either side
  logic hold_toggle = 1'b0;   // flip to request a long receiver hold-off
  logic hold_seen = 1'b0;
  int stall_left = 0;

  // atan(2^-i) in degrees, Q16.16
  longint atan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  tilt_complementary_filter_unit #(
    .CORDIC_ITERATIONS(CordicIters)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp_q32(input longint v);
    if (v > Q32Max) return Q32Max;
    if (v < Q32Min) return Q32Min;
    return v;
  endfunction

  // atan2(ay, ax) in degrees, Q16.16, vectoring CORDIC
  function automatic longint accel_pitch_q16(input longint ay, input longint ax);
    longint z, cx, cy, dx, dy;
    int n, i;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    if (ax < 0) begin
      z = (ay >= 0) ? HalfTurnQ16 : -HalfTurnQ16;
      ax = -ax;
      ay = -ay;
    end
    n = (CordicIters > 24) ? 24 : CordicIters;
    cx = ax * 65536;
    cy = ay * 65536;
    for (i = 0; i < n; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx;
        cy -= dy;
        z += atan_q16[i];
      end else begin
        cx -= dx;
        cy += dy;
        z -= atan_q16[i];
      end
    end
    return z;
  endfunction

  function automatic tcf_out_t predict_tilt(input tcf_in_t s);
    longint ax, az, gy, gz, acc_q16, incr, blend, rate, deg;
    tcf_out_t r;
    ax = longint'($signed(s.accel_x_raw));
    az = longint'($signed(s.accel_z_raw));
    gy = longint'($signed(s.gyro_pitch_raw));
    gz = longint'($signed(s.gyro_yaw_raw));
    acc_q16 = accel_pitch_q16(ax, az);
    incr = (gy * step_period * 5) / 82;
    blend = (65536 - trust_weight) * (pitch_est_q16 - incr) + trust_weight * acc_q16;
    pitch_est_q16 = clamp_q32(blend >>> 16);
    rate = (gz * 5) / 82;
    yaw_acc_q16 = clamp_q32(yaw_acc_q16 + rate * step_period);
    if (s.publish_pitch) begin
      deg = pitch_est_q16 / 65536;
      if (deg > 255) deg = 255;
      if (deg < -256) deg = -256;
      pitch_hold = 9'(deg);
    end
    r.pitch_degrees = pitch_hold;
    r.yaw_degrees = 16'(yaw_acc_q16 / 65536);
    return r;
  endfunction

  function automatic tcf_in_t mk_sample(input int ax, input int az, input int gy,
                                        input int gz, input int pub);
    tcf_in_t s;
    s.accel_x_raw = 16'(ax);
    s.accel_z_raw = 16'(az);
    s.gyro_pitch_raw = 16'(gy);
    s.gyro_yaw_raw = 16'(gz);
    s.publish_pitch = 1'(pub);
    return s;
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic tcf_in_t rand_sample();
    tcf_in_t s;
    s.accel_x_raw = 16'($urandom);
    s.accel_z_raw = 16'($urandom);
    s.gyro_pitch_raw = 16'($urandom);
    s.gyro_yaw_raw = 16'($urandom);
    s.publish_pitch = 1'($urandom);
    case ($urandom_range(7))
      0: begin
        s.accel_x_raw = pick_edge();
        s.accel_z_raw = pick_edge();
      end
      1: begin
        s.gyro_pitch_raw = pick_edge();
        s.gyro_yaw_raw = pick_edge();
      end
      2: begin
        // roughly level board, 1 g on z
        s.accel_x_raw = 16'($urandom_range(1024)) - 16'd512;
        s.accel_z_raw = 16'd3968 + 16'($urandom_range(256));
        s.gyro_pitch_raw = 16'($urandom_range(2048)) - 16'd1024;
      end
      3: begin
        if ($urandom_range(1)) s.accel_x_raw = '0;
        else s.accel_z_raw = '0;
      end
      4: begin
        s.accel_x_raw = 16'($urandom_range(8)) - 16'd4;
        s.accel_z_raw = 16'($urandom_range(8)) - 16'd4;
      end
      default: ;
    endcase
    return s;
  endfunction

  // one sample transfer; valid stays up when the next sample follows at once
  task automatic send_sample(input tcf_in_t s);
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    tilt_results_q.push_back(predict_tilt(s));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WEIGHT: trust_weight = longint'(data);
      CFG_PERIOD: step_period = longint'(data);
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the filter has delivered everything and gone quiet
  task automatic settle_filter();
    in_valid_i <= 1'b0;
    while (tilt_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_sample(mk_sample(0, 0, 0, 0, 1));            // both accel axes zero
    send_sample(mk_sample(0, -4096, 0, 0, 1));        // x zero, z negative: +180
    send_sample(mk_sample(4096, -4096, 0, 0, 1));
    send_sample(mk_sample(-4096, -4096, 0, 0, 1));    // mirrored to -180 side
    send_sample(mk_sample(0, 4096, 0, 0, 0));         // y starts at zero in CORDIC, x positive
    send_sample(mk_sample(4096, 0, 0, 0, 1));
    send_sample(mk_sample(-4096, 0, 0, 0, 1));
    send_sample(mk_sample(32767, 32767, 0, 0, 1));
    send_sample(mk_sample(-32768, -32768, 0, 0, 1));
    send_sample(mk_sample(32767, -32768, 0, 0, 0));
    send_sample(mk_sample(-32768, 32767, 0, 0, 1));
    send_sample(mk_sample(1, -1, 0, 0, 1));
    send_sample(mk_sample(-1, 1, 0, 0, 1));
    send_sample(mk_sample(1, 1, 0, 0, 1));
    send_sample(mk_sample(0, -1, 0, 0, 1));
    send_sample(mk_sample(0, 0, 32767, -32768, 1));
    send_sample(mk_sample(0, 0, -32768, 32767, 0));
    send_sample(mk_sample(100, 4000, 81, 82, 1));     // gyro just under/at 5 deg/s
    send_sample(mk_sample(-100, 4000, -82, -81, 1));
    send_sample(mk_sample(-1, -1, -1, -1, 1));
    settle_filter();
  endtask

  // drive both accumulators into saturation, up and then down
  task automatic test_saturation();
    int k;
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_PERIOD, 16'hFFFF);
    end_cfg();
    for (k = 0; k < 24; k++) begin
      send_sample(mk_sample(int'($urandom_range(65535)), 4096, -32768, 32767, 1));
    end
    for (k = 0; k < 40; k++) begin
      send_sample(mk_sample(-4096, int'($urandom_range(65535)), 32767, -32768, k % 3 != 1));
    end
    settle_filter();
  endtask

  task automatic test_backpressure();
    int k;
    write_reg(CFG_WEIGHT, 16'd32768);
    write_reg(CFG_PERIOD, 16'd4096);
    end_cfg();
    hold_toggle <= ~hold_toggle;
    for (k = 0; k < 30; k++) send_sample(rand_sample());
    settle_filter();
  endtask

  task automatic test_random();
    logic [15:0] weights [0:6];
    logic [15:0] periods [0:6];
    int ph, k;
    weights = '{WeightRst, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'($urandom), 16'($urandom)};
    periods = '{PeriodRst, 16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'($urandom), 16'($urandom)};
    for (ph = 0; ph < 7; ph++) begin
      write_reg(CFG_WEIGHT, weights[ph]);
      write_reg(CFG_PERIOD, periods[ph]);
      if (ph == 5) begin
        write_reg(CfgSpareLo, 16'($urandom));
        write_reg(CfgSpareHi, 16'($urandom));
      end
      end_cfg();
      if (ph == 2) steady <= 1'b1;
      for (k = 0; k < 250; k++) send_sample(rand_sample());
      steady <= 1'b0;
      settle_filter();
    end
  endtask

  // receiver: random ready, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      stall_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : check_results
    tcf_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tilt_results_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result pitch %0d yaw %0d", $time,
                 $signed(out_data_o.pitch_degrees), $signed(out_data_o.yaw_degrees));
      end else begin
        want = tilt_results_q.pop_front();
        if (out_data_o.pitch_degrees !== want.pitch_degrees) begin
          fail_count++;
          $display("%0t: pitch_degrees expected %0d actual %0d", $time,
                   $signed(want.pitch_degrees), $signed(out_data_o.pitch_degrees));
        end
        if (out_data_o.yaw_degrees !== want.yaw_degrees) begin
          fail_count++;
          $display("%0t: yaw_degrees expected %0d actual %0d", $time,
                   $signed(want.yaw_degrees), $signed(out_data_o.yaw_degrees));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WEIGHT;
    cfg_data_i = '0;
    pitch_est_q16 = 0;
    yaw_acc_q16 = 0;
    pitch_hold = '0;
    trust_weight = longint'(WeightRst);
    step_period = longint'(PeriodRst);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_saturation();
    test_backpressure();
    test_random();
    settle_filter();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
